FILE: design/ufr_pkg.sv
// ----------------------------------------------------------------------------
// ufr_pkg
// Shared types and codes for the UART register block with receive FIFO.
// ----------------------------------------------------------------------------
package ufr_pkg;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_TICK   = 2'd2,
    OP_INJECT = 2'd3
  } ufr_op_e;

  localparam logic [2:0] PORT_RX_DATA = 3'd0;
  localparam logic [2:0] PORT_RX_STAT = 3'd1;
  localparam logic [2:0] PORT_TX_DATA = 3'd2;
  localparam logic [2:0] PORT_TX_STAT = 3'd3;
  localparam logic [2:0] PORT_CONFIG  = 3'd4;

  localparam int unsigned CfgEnBit    = 0;
  localparam int unsigned CfgIeBit    = 1;
  localparam int unsigned CfgLoopBit  = 2;
  localparam int unsigned CfgDelayLsb = 8;

  localparam int unsigned StReadyBit = 0;
  localparam int unsigned StOvfBit   = 1;

  localparam logic [7:0] EMPTY_BYTE = 8'hff;

  typedef struct packed {
    logic push;
    logic pop;
    logic clr_ovf;
  } ufr_fifo_req_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic overrun;
  } ufr_fifo_sts_t;

  typedef struct packed {
    logic send;
    logic tick;
    logic stop;
    logic clr_ovf;
  } ufr_tx_req_t;

  typedef struct packed {
    logic busy;
    logic overrun;
    logic cnt_zero;
  } ufr_tx_sts_t;

endpackage

FILE: design/ufr_rx_fifo.sv
// ----------------------------------------------------------------------------
// ufr_rx_fifo
// Ring receive FIFO with fill count, overrun flag and registered read data.
// ----------------------------------------------------------------------------
module ufr_rx_fifo #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ufr_pkg::ufr_fifo_req_t req_i,
  input  logic [7:0]             wr_data_i,
  output ufr_pkg::ufr_fifo_sts_t sts_o,
  output logic [7:0]             rd_data_o
);
  import ufr_pkg::*;

  localparam int unsigned AddrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW  = $clog2(FIFO_DEPTH + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(FIFO_DEPTH);

  logic [7:0]       mem_q [FIFO_DEPTH];
  logic [7:0]       rd_data_q;
  logic [AddrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             ovf_q, ovf_d;
  logic             empty, full, do_push, do_pop;

  assign empty   = (fill_q == '0);
  assign full    = (fill_q == FullCnt);
  assign do_push = req_i.push && !full;
  assign do_pop  = req_i.pop && !empty;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    ovf_d  = ovf_q;
    if (do_push) begin
      tail_d = (tail_q == LastAddr) ? '0 : tail_q + 1'b1;
      fill_d = fill_q + 1'b1;
    end else if (do_pop) begin
      head_d = (head_q == LastAddr) ? '0 : head_q + 1'b1;
      fill_d = fill_q - 1'b1;
    end
    if (req_i.push && full) begin
      ovf_d = 1'b1;
    end else if (req_i.clr_ovf) begin
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[tail_q] <= wr_data_i;
    end
    if (do_pop) begin
      rd_data_q <= mem_q[head_q];
    end
  end

  assign sts_o.empty   = empty;
  assign sts_o.full    = full;
  assign sts_o.overrun = ovf_q;
  assign rd_data_o     = rd_data_q;

endmodule

FILE: design/ufr_tx_timer.sv
// ----------------------------------------------------------------------------
// ufr_tx_timer
// Transmit busy countdown and transmit overrun flag.
// ----------------------------------------------------------------------------
module ufr_tx_timer #(
  parameter int unsigned DELAY_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ufr_pkg::ufr_tx_req_t  req_i,
  input  logic [DELAY_BITS-1:0] delay_i,
  output ufr_pkg::ufr_tx_sts_t  sts_o
);
  import ufr_pkg::*;

  logic                  busy_q, busy_d;
  logic                  ovf_q, ovf_d;
  logic [DELAY_BITS-1:0] cnt_q, cnt_d, cnt_dec;

  assign cnt_dec = (cnt_q != '0) ? cnt_q - 1'b1 : '0;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    if (req_i.stop) begin
      busy_d = 1'b0;
      cnt_d  = '0;
    end else if (req_i.send) begin
      if (busy_q) begin
        ovf_d = 1'b1;
      end else if (delay_i != '0) begin
        busy_d = 1'b1;
        cnt_d  = delay_i;
      end
    end else if (req_i.tick && busy_q) begin
      cnt_d = cnt_dec;
      if (cnt_dec == '0) begin
        busy_d = 1'b0;
      end
    end
    if (req_i.clr_ovf) begin
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
    end
  end

  assign sts_o.busy     = busy_q;
  assign sts_o.overrun  = ovf_q;
  assign sts_o.cnt_zero = (cnt_q == '0);

endmodule

FILE: design/uart_fifo_register_block.sv
// ----------------------------------------------------------------------------
// uart_fifo_register_block
// UART register block: config word, receive FIFO, transmit busy timer.
//
//   channel | valid       | stall        | fields
//   --------+-------------+--------------+-----------------------------------
//   in      | in_valid_i  | in_stall_o   | op_i, port_i, wdata_i, rx_byte_i
//   out     | out_valid_o | out_stall_i  | rdata_o, irq_pulse_o, tx_valid_o,
//           |             |              | tx_byte_o
//
// One item per cycle while the output is not stalled; the accepting edge
// loads the input register, and the result register is loaded from it when
// the output advances. The decode and state update for an item sit between
// those two registers. Reset clears the config word, FIFO pointers and flags;
// FIFO contents are left as they are. A stalled output holds the result
// register and backs up into the input register.
// ----------------------------------------------------------------------------
module uart_fifo_register_block #(
  parameter int unsigned FIFO_DEPTH = 16,
  parameter int unsigned DELAY_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [2:0]  port_i,
  input  logic [31:0] wdata_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] rdata_o,
  output logic        irq_pulse_o,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o
);
  import ufr_pkg::*;

  // input register
  logic        in_vld_q;
  ufr_op_e     op_q;
  logic [2:0]  port_q;
  logic [31:0] wdata_q;
  logic [7:0]  rxb_q;

  // result register
  logic        out_vld_q;
  logic [31:0] rdata_q;
  logic        pop_sel_q;
  logic        irq_q, txv_q;
  logic [7:0]  txb_q;

  logic [31:0] cfg_q, cfg_d;

  logic advance, fire, en;

  ufr_fifo_req_t fifo_req;
  ufr_fifo_sts_t fifo_sts;
  ufr_tx_req_t   tx_req;
  ufr_tx_sts_t   tx_sts;
  logic [7:0]    fifo_wdata, fifo_rdata;

  logic [31:0] rdata_d;
  logic        pop_sel_d, irq_d, txv_d;
  logic [7:0]  txb_d;

  assign advance    = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;
  assign en         = cfg_q[CfgEnBit];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q    <= ufr_op_e'(op_i);
      port_q  <= port_i;
      wdata_q <= wdata_i;
      rxb_q   <= rx_byte_i;
    end
  end

  always_comb begin
    cfg_d      = cfg_q;
    rdata_d    = '0;
    pop_sel_d  = 1'b0;
    irq_d      = 1'b0;
    txv_d      = 1'b0;
    txb_d      = '0;
    fifo_req   = '0;
    fifo_wdata = rxb_q;
    tx_req     = '0;
    unique case (op_q)
      OP_READ: begin
        unique case (port_q)
          PORT_RX_DATA: begin
            if (en && !fifo_sts.empty) begin
              fifo_req.pop = 1'b1;
              pop_sel_d    = 1'b1;
            end else begin
              rdata_d = {24'd0, EMPTY_BYTE};
            end
          end
          PORT_RX_STAT: begin
            if (en) begin
              rdata_d[StReadyBit] = !fifo_sts.empty;
              rdata_d[StOvfBit]   = fifo_sts.overrun;
            end
          end
          PORT_TX_STAT: begin
            if (en) begin
              rdata_d[StReadyBit] = !tx_sts.busy;
              rdata_d[StOvfBit]   = tx_sts.overrun;
            end
          end
          PORT_CONFIG: rdata_d = cfg_q;
          default:     rdata_d = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (port_q)
          PORT_RX_STAT: fifo_req.clr_ovf = wdata_q[StOvfBit];
          PORT_TX_DATA: begin
            if (en) begin
              tx_req.send = 1'b1;
              if (!tx_sts.busy) begin
                txv_d = 1'b1;
                txb_d = wdata_q[7:0];
                if (cfg_q[CfgLoopBit]) begin
                  fifo_req.push = 1'b1;
                  fifo_wdata    = wdata_q[7:0];
                  irq_d         = cfg_q[CfgIeBit];
                end
              end
            end
          end
          PORT_TX_STAT: tx_req.clr_ovf = wdata_q[StOvfBit];
          PORT_CONFIG: begin
            cfg_d       = wdata_q;
            tx_req.stop = !wdata_q[CfgEnBit];
          end
          default: ;
        endcase
      end
      OP_TICK: tx_req.tick = en && tx_sts.busy;
      OP_INJECT: begin
        if (en) begin
          fifo_req.push = 1'b1;
          irq_d         = cfg_q[CfgIeBit];
        end
      end
      default: ;
    endcase
    if (!fire) begin
      cfg_d    = cfg_q;
      fifo_req = '0;
      tx_req   = '0;
    end
  end

  ufr_rx_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_rx_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (fifo_req),
    .wr_data_i(fifo_wdata),
    .sts_o    (fifo_sts),
    .rd_data_o(fifo_rdata)
  );

  ufr_tx_timer #(
    .DELAY_BITS(DELAY_BITS)
  ) u_tx_timer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tx_req),
    .delay_i(cfg_q[CfgDelayLsb +: DELAY_BITS]),
    .sts_o  (tx_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rdata_q   <= rdata_d;
      pop_sel_q <= pop_sel_d;
      irq_q     <= irq_d;
      txv_q     <= txv_d;
      txb_q     <= txb_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign rdata_o     = pop_sel_q ? {24'd0, fifo_rdata} : rdata_q;
  assign irq_pulse_o = irq_q;
  assign tx_valid_o  = txv_q;
  assign tx_byte_o   = txb_q;

`ifndef SYNTH
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("input stalled with empty input register");

  a_fifo_not_empty_and_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_sts.empty && fifo_sts.full))
    else $error("receive FIFO empty and full at once");

  a_busy_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_sts.busy |-> !tx_sts.cnt_zero)
    else $error("transmitter busy with zero countdown");

  a_tx_result_no_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && txv_q) |-> (rdata_o == '0))
    else $error("transmit result carries read data");
`endif

endmodule
